>>> design/usst_pkg.sv
// Shared types, register codes and arithmetic helpers for the ranger/servo timer.
// No dependencies; imported by ultrasonic_ranger_servo_sweep_timer.
package usst_pkg;

    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_PER_MIN = 60;
    localparam int US_MAX      = 999;

    // floor(y/29) = (y * DIV29_MUL) >> DIV29_SHIFT, exact for y < 2^19
    localparam int DIV29_MUL   = 578525;
    localparam int DIV29_SHIFT = 24;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_INTV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_SPAN = 3'd5;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ECHO = 1'b1;

    typedef struct packed {
        logic [5:0] sec;
        logic [9:0] ms;
    } tstamp_t;

    // now + dur ms, ms wrapping at 1000 into seconds, seconds wrapping at 60
    function automatic tstamp_t sched_after(logic [5:0] sec, logic [9:0] ms, logic [9:0] dur);
        logic [10:0] total;
        logic [6:0]  s;
        tstamp_t     r;
        total = {1'b0, ms} + {1'b0, dur};
        s     = {1'b0, sec};
        if (total >= 11'(2 * MS_PER_SEC))
        begin
            total = total - 11'(2 * MS_PER_SEC);
            s     = s + 7'd2;
        end
        else if (total >= 11'(MS_PER_SEC))
        begin
            total = total - 11'(MS_PER_SEC);
            s     = s + 7'd1;
        end
        if (s >= 7'(SEC_PER_MIN))
        begin
            s = s - 7'(SEC_PER_MIN);
        end
        r.sec = s[5:0];
        r.ms  = total[9:0];
        return r;
    endfunction

    // elapsed microseconds between two (ms, us) stamps, with borrow
    function automatic logic [19:0] echo_us(logic [9:0] s_ms, logic [9:0] s_us,
                                            logic [9:0] e_ms, logic [9:0] e_us);
        logic [10:0] d_ms;
        logic [10:0] d_us;
        if (e_ms >= s_ms)
        begin
            d_ms = {1'b0, e_ms} - {1'b0, s_ms};
        end
        else
        begin
            d_ms = 11'(MS_PER_SEC) - {1'b0, s_ms} + {1'b0, e_ms};
        end
        if (e_us >= s_us)
        begin
            d_us = {1'b0, e_us} - {1'b0, s_us};
        end
        else
        begin
            d_us = 11'(MS_PER_SEC) - {1'b0, s_us} + {1'b0, e_us};
            if (d_ms != 11'd0)
            begin
                d_ms = d_ms - 11'd1;
            end
        end
        return 20'(20'(d_ms) * 20'(MS_PER_SEC)) + 20'(d_us);
    endfunction

    // x / 58 = (x >> 1) / 29
    function automatic logic [14:0] div58(logic [19:0] x);
        logic [38:0] prod;
        prod = 39'(x[19:1]) * 39'(DIV29_MUL);
        return prod[DIV29_SHIFT+14:DIV29_SHIFT];
    endfunction

endpackage

>>> design/ultrasonic_ranger_servo_sweep_timer.sv
// Ultrasonic ranger trigger scheduler, servo sweep and echo distance timer.
// Depends on usst_pkg (types, register codes, schedule/echo/divide helpers).
//
// Usage:
//   Item channel (item_valid/item_stall, cmd, capture_us): cmd = tick advances
//   the sec/ms clock by one ms and fires the trigger and servo schedules; cmd =
//   echo records an echo edge, the closing edge of each pair finishing a distance.
//   Result channel (result_valid/result_stall): one word per item with the
//   trigger level, servo compare, last distance and a new-distance flag.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; write only while no items are in flight.
// Timing:
//   One item per cycle while result_stall is low: schedule and sweep updates
//   plus echo-time subtraction settle in the first stage, the divide by 58
//   (reciprocal multiply) in the second, both registered before result_valid.
// Reset (rst_n low, async): clock 00:000, first trigger rise at ms 60, first
//   servo update at ms 20, config registers to their defaults, pipeline empty.
// Stall: a stalled result holds in the output register; one more item can be
//   taken into the first stage, after which item_stall rises until it drains.
module ultrasonic_ranger_servo_sweep_timer
    import usst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  cmd,
    input  logic [9:0]            capture_us,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  trig_level,
    output logic [15:0]           servo_compare,
    output logic [14:0]           distance_cm,
    output logic                  distance_new,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration ----------------
    logic [9:0]  trig_high_reg;
    logic [9:0]  trig_low_reg;
    logic [9:0]  servo_intv_reg;
    logic [10:0] servo_step_reg;
    logic [14:0] servo_min_reg;
    logic [14:0] servo_span_reg;

    // ---------------- block state ----------------
    logic [9:0]  clock_ms_reg,   clock_ms_next;
    logic [5:0]  clock_sec_reg,  clock_sec_next;
    tstamp_t     rise_time_reg,  rise_time_next;
    tstamp_t     fall_time_reg,  fall_time_next;
    logic        fall_armed_reg, fall_armed_next;
    tstamp_t     servo_time_reg, servo_time_next;
    logic [14:0] servo_pos_reg,  servo_pos_next;
    logic        servo_dir_reg,  servo_dir_next;
    logic [15:0] servo_width_reg, servo_width_next;
    logic        trig_reg,       trig_next;
    logic        edge_idx_reg,   edge_idx_next;
    logic [19:0] first_edge_reg;
    logic [14:0] distance_reg;

    // ---------------- pipeline ----------------
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_trig_reg;
    logic [15:0] s1_servo_reg;
    logic        s1_fresh_reg;
    logic [19:0] s1_echo_us_reg;

    logic        result_valid_reg, result_valid_next;
    logic        trig_level_reg;
    logic [15:0] servo_compare_reg;
    logic [14:0] distance_cm_reg;
    logic        distance_new_reg;

    logic        item_accept;
    logic        out_load;
    logic        cfg_write;

    // ---------------- first stage combinational ----------------
    tstamp_t     now;
    tstamp_t     sched_high;
    tstamp_t     sched_low;
    tstamp_t     sched_servo;
    tstamp_t     fall_eff;
    logic        rise_hit;
    logic        fall_hit;
    logic        servo_hit;
    logic [9:0]  cap_sat;
    logic [14:0] pos_base;
    logic [15:0] pos_sum;
    logic [15:0] width_up;
    logic [15:0] width_dn;
    logic        fresh;
    logic [19:0] echo_us_val;
    logic [14:0] dist_q;
    logic [14:0] dist_out;

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid & cfg_ready;

    // second stage frees up when output is empty or being taken
    assign out_load     = s1_valid_reg & ~(result_valid_reg & result_stall);
    assign item_stall   = s1_valid_reg & result_valid_reg & result_stall;
    assign item_accept  = item_valid & ~item_stall;

    always_comb
    begin
        // clock advance (tick only)
        if (clock_ms_reg >= 10'(MS_PER_SEC - 1))
        begin
            clock_ms_next  = 10'd0;
            clock_sec_next = (clock_sec_reg >= 6'(SEC_PER_MIN - 1)) ? 6'd0
                                                                    : clock_sec_reg + 6'd1;
        end
        else
        begin
            clock_ms_next  = clock_ms_reg + 10'd1;
            clock_sec_next = clock_sec_reg;
        end
        now.sec = clock_sec_next;
        now.ms  = clock_ms_next;

        sched_high  = sched_after(now.sec, now.ms, trig_high_reg);
        sched_low   = sched_after(now.sec, now.ms, trig_low_reg);
        sched_servo = sched_after(now.sec, now.ms, servo_intv_reg);

        // rise, then fall against the freshly scheduled fall time
        rise_hit = (now == rise_time_reg);
        fall_eff = rise_hit ? sched_high : fall_time_reg;
        fall_hit = (fall_armed_reg | rise_hit) & (now == fall_eff);
        servo_hit = (now == servo_time_reg);

        // sweep: restart and reverse on reaching the span, then step, clamp
        width_up = 16'(servo_min_reg) + 16'(servo_pos_reg);
        width_dn = 16'(servo_min_reg) + 16'(servo_span_reg) - 16'(servo_pos_reg);
        pos_base = (servo_pos_reg == servo_span_reg) ? 15'd0 : servo_pos_reg;
        pos_sum  = 16'(pos_base) + 16'(servo_step_reg);

        cap_sat     = (capture_us > 10'(US_MAX)) ? 10'(US_MAX) : capture_us;
        echo_us_val = echo_us(first_edge_reg[19:10], first_edge_reg[9:0],
                              clock_ms_reg, cap_sat);

        clock_ms_next   = (cmd == CMD_TICK) ? clock_ms_next : clock_ms_reg;
        clock_sec_next  = (cmd == CMD_TICK) ? clock_sec_next : clock_sec_reg;
        rise_time_next  = rise_time_reg;
        fall_time_next  = fall_time_reg;
        fall_armed_next = fall_armed_reg;
        servo_time_next = servo_time_reg;
        servo_pos_next  = servo_pos_reg;
        servo_dir_next  = servo_dir_reg;
        servo_width_next = servo_width_reg;
        trig_next       = trig_reg;
        edge_idx_next   = edge_idx_reg;
        fresh           = 1'b0;

        if (item_accept)
        begin
            unique case (cmd)
                CMD_TICK:
                begin
                    fall_time_next  = fall_eff;
                    fall_armed_next = fall_armed_reg | rise_hit;
                    if (fall_hit)
                    begin
                        trig_next      = 1'b0;
                        rise_time_next = sched_low;
                    end
                    else if (rise_hit)
                    begin
                        trig_next = 1'b1;
                    end
                    if (servo_hit)
                    begin
                        servo_width_next = servo_dir_reg ? width_dn : width_up;
                        if (servo_pos_reg == servo_span_reg)
                        begin
                            servo_dir_next = ~servo_dir_reg;
                        end
                        servo_pos_next  = (pos_sum > 16'(servo_span_reg)) ? servo_span_reg
                                                                          : pos_sum[14:0];
                        servo_time_next = sched_servo;
                    end
                end
                CMD_ECHO:
                begin
                    edge_idx_next = ~edge_idx_reg;
                    fresh         = edge_idx_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (cfg_write && cfg_index == CFG_SERVO_SPAN)
        begin
            // new span clamps the current position
            if (servo_pos_reg > cfg_data)
            begin
                servo_pos_next = cfg_data;
            end
        end
    end

    // second stage: divide by 58, distance hold
    assign dist_q   = div58(s1_echo_us_reg);
    assign dist_out = s1_fresh_reg ? dist_q : distance_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_high_reg  <= 10'd10;
            trig_low_reg   <= 10'd60;
            servo_intv_reg <= 10'd10;
            servo_step_reg <= 11'd5;
            servo_min_reg  <= 15'd500;
            servo_span_reg <= 15'd2000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TRIG_HIGH:  trig_high_reg  <= cfg_data[9:0];
                CFG_TRIG_LOW:   trig_low_reg   <= cfg_data[9:0];
                CFG_SERVO_INTV: servo_intv_reg <= cfg_data[9:0];
                CFG_SERVO_STEP: servo_step_reg <= cfg_data[10:0];
                CFG_SERVO_MIN:  servo_min_reg  <= cfg_data;
                CFG_SERVO_SPAN: servo_span_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // block state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_ms_reg     <= 10'd0;
            clock_sec_reg    <= 6'd0;
            rise_time_reg    <= '{sec: 6'd0, ms: 10'd60};
            fall_time_reg    <= '0;
            fall_armed_reg   <= 1'b0;
            servo_time_reg   <= '{sec: 6'd0, ms: 10'd20};
            servo_pos_reg    <= 15'd0;
            servo_dir_reg    <= 1'b0;
            servo_width_reg  <= 16'd0;
            trig_reg         <= 1'b0;
            edge_idx_reg     <= 1'b0;
            distance_reg     <= 15'd0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                clock_ms_reg  <= clock_ms_next;
                clock_sec_reg <= clock_sec_next;
            end
            rise_time_reg    <= rise_time_next;
            fall_time_reg    <= fall_time_next;
            fall_armed_reg   <= fall_armed_next;
            servo_time_reg   <= servo_time_next;
            servo_pos_reg    <= servo_pos_next;
            servo_dir_reg    <= servo_dir_next;
            servo_width_reg  <= servo_width_next;
            trig_reg         <= trig_next;
            edge_idx_reg     <= edge_idx_next;
            if (out_load && s1_fresh_reg)
            begin
                distance_reg <= dist_q;
            end
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_trig_reg    <= trig_next;
            s1_servo_reg   <= servo_width_next;
            s1_fresh_reg   <= fresh;
            s1_echo_us_reg <= echo_us_val;
            if (cmd == CMD_ECHO && !edge_idx_reg)
            begin
                first_edge_reg <= {clock_ms_reg, cap_sat};
            end
        end
        if (out_load)
        begin
            trig_level_reg    <= s1_trig_reg;
            servo_compare_reg <= s1_servo_reg;
            distance_cm_reg   <= dist_out;
            distance_new_reg  <= s1_fresh_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign trig_level    = trig_level_reg;
    assign servo_compare = servo_compare_reg;
    assign distance_cm   = distance_cm_reg;
    assign distance_new  = distance_new_reg;

    // ---------------- checks ----------------
    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        clock_ms_reg < 10'(MS_PER_SEC) && clock_sec_reg < 6'(SEC_PER_MIN))
        else $error("clock out of range");

    a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        servo_pos_reg <= servo_span_reg)
        else $error("servo position beyond span");

    a_fresh_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && distance_new_reg |-> distance_cm_reg == distance_reg)
        else $error("fresh distance differs from held distance");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result_valid_reg && result_stall |=> s1_valid_reg)
        else $error("first stage dropped a word under stall");

endmodule
